### rtl/odm_pkg.sv
package odm_pkg;

	localparam int DIST_W     = 13;
	localparam int SPD_W      = 16;
	localparam int VEL_W      = 18;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 15;

	localparam int MUL_A_W = 19;
	localparam int MUL_B_W = 23;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CRUISE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SENS   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 3'd3;

	localparam logic [14:0] CRUISE_RST = 15'd12288;
	localparam logic [14:0] MIN_RST    = 15'd410;
	localparam logic [12:0] SENS_RST   = 13'd819;
	localparam logic [14:0] GAIN_RST   = 15'd12288;

	// reciprocals scaled by 2^24, exact for the operand ranges used here
	localparam logic signed [MUL_B_W-1:0] RECIP_25 = 23'sd671089;
	localparam logic signed [MUL_B_W-1:0] RECIP_35 = 23'sd479350;
	localparam logic signed [MUL_B_W-1:0] RECIP_5  = 23'sd3355444;

	typedef struct packed {
		logic [14:0] cruise;
		logic [14:0] min_spd;
		logic [12:0] sens;
		logic [14:0] gain;
	} cfg_regs_t;

	typedef struct packed {
		logic        ld;
		logic [14:0] val;
	} cruise_ld_t;

endpackage

### rtl/odm_mul.sv
module odm_mul import odm_pkg::*; (
	input  logic                       clk,
	input  logic signed [MUL_A_W-1:0] a,
	input  logic signed [MUL_B_W-1:0] b,
	output logic signed [MUL_P_W-1:0] p_q
);

	always_ff @(posedge clk) begin
		p_q <= MUL_P_W'(a) * MUL_P_W'(b);
	end

endmodule

### rtl/odm_cfg.sv
module odm_cfg import odm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_regs_t             regs,
	output cruise_ld_t            cruise_ld
);

	cfg_regs_t regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.cruise  <= CRUISE_RST;
			regs_q.min_spd <= MIN_RST;
			regs_q.sens    <= SENS_RST;
			regs_q.gain    <= GAIN_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_CRUISE: regs_q.cruise  <= cfg_data;
				REG_MIN:    regs_q.min_spd <= cfg_data;
				REG_SENS:   regs_q.sens    <= cfg_data[12:0];
				REG_GAIN:   regs_q.gain    <= cfg_data;
				default:    ;
			endcase
		end
	end

	assign regs          = regs_q;
	assign cruise_ld.ld  = cfg_valid && (cfg_index == REG_CRUISE);
	assign cruise_ld.val = cfg_data;

endmodule

### rtl/odm_core.sv
module odm_core import odm_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cfg_regs_t                cfg,
	input  cruise_ld_t               cruise_ld,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [DIST_W-1:0]        front_left_dist,
	input  logic [DIST_W-1:0]        front_center_dist,
	input  logic [DIST_W-1:0]        front_right_dist,
	input  logic [DIST_W-1:0]        rear_left_dist,
	input  logic [DIST_W-1:0]        rear_center_dist,
	input  logic [DIST_W-1:0]        rear_right_dist,
	input  logic [DIST_W-1:0]        side_left_dist,
	input  logic [DIST_W-1:0]        side_right_dist,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [SPD_W-1:0] left_speed,
	output logic signed [SPD_W-1:0] right_speed,
	output logic signed [VEL_W-1:0] left_motor_vel,
	output logic signed [VEL_W-1:0] right_motor_vel,
	output logic                     front_sense_on,
	output logic                     rear_sense_on
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_CLR   = 4'd1;
	localparam logic [3:0] S_ANGL  = 4'd2;
	localparam logic [3:0] S_A     = 4'd3;
	localparam logic [3:0] S_ANGR  = 4'd4;
	localparam logic [3:0] S_B     = 4'd5;
	localparam logic [3:0] S_SIDEL = 4'd6;
	localparam logic [3:0] S_SIDER = 4'd7;
	localparam logic [3:0] S_ML    = 4'd8;
	localparam logic [3:0] S_MR    = 4'd9;
	localparam logic [3:0] S_GL    = 4'd10;
	localparam logic [3:0] S_GR    = 4'd11;
	localparam logic [3:0] S_DONE  = 4'd12;

	function automatic logic signed [SPD_W-1:0] sat16(input logic signed [19:0] v);
		if (v > 20'sd32767)
			return 16'sh7fff;
		else if (v < -20'sd32768)
			return 16'sh8000;
		else
			return v[15:0];
	endfunction

	function automatic logic signed [VEL_W-1:0] sat18(input logic signed [19:0] v);
		if (v > 20'sd131071)
			return 18'sh1ffff;
		else if (v < -20'sd131072)
			return 18'sh20000;
		else
			return v[17:0];
	endfunction

	logic [3:0]              state_q;
	logic                    ph_q;
	logic [DIST_W-1:0]       dl_q, dc_q, dr_q, sl_q, sr_q;
	logic                    back_q, rev_q, fresh_q;
	logic signed [15:0]      wanted_q, prev_l_q, prev_r_q;
	logic signed [13:0]      clr_q;
	logic [12:0]             ang_q, a_q, b_q, sdl_q, sdr_q;
	logic signed [15:0]      nl_q, nr_q;
	logic signed [17:0]      mvl_q, mvr_q;
	logic                    out_valid_q;
	logic signed [15:0]      ls_q, rs_q;
	logic signed [17:0]      lmv_q, rmv_q;
	logic                    fs_q, rsn_q;

	logic                    accept;
	logic signed [17:0]      sum18, thr18;
	logic                    go_fwd, go_back;
	logic signed [15:0]      wanted_neg;

	logic [12:0]             mn;
	logic [9:0]              u;
	logic [16:0]             x_clr;
	logic [12:0]             d_ang, d_sd;
	logic [10:0]             s_ang;
	logic [17:0]             x_ang;
	logic [7:0]              c_sd;
	logic [14:0]             x_sd;
	logic signed [13:0]      sd;
	logic signed [16:0]      clr17, a17, b17, sd17, m_l, m_r;
	logic signed [16:0]      nr_neg;

	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [MUL_P_W-1:0] p_q;

	logic signed [20:0]      pw;
	logic signed [21:0]      spd_sum;
	logic signed [15:0]      spd_new;
	logic signed [17:0]      vel_new;

	odm_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (p_q)
	);

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;

	// direction decision from the previous speeds
	assign sum18   = 18'(prev_l_q) + 18'(prev_r_q);
	assign thr18   = $signed({2'b00, cfg.min_spd, 1'b0});
	assign go_fwd  = fresh_q || (sum18 > thr18);
	assign go_back = !fresh_q && (sum18 < -thr18);
	assign wanted_neg = (wanted_q == 16'sh8000) ? 16'sh7fff : -wanted_q;

	// clearance operand: (min(m,920)*128 + 15), quotient by 25 minus 615
	always_comb begin
		mn = dl_q;
		if (dc_q < mn)
			mn = dc_q;
		if (dr_q < mn)
			mn = dr_q;
	end
	assign u     = (mn > 13'd920) ? 10'd920 : mn[9:0];
	assign x_clr = {u, 7'b0} + 17'd15;

	assign d_ang = (state_q == S_ANGL) ? dl_q : dr_q;
	assign s_ang = (d_ang < 13'd1120) ? 11'(13'd1120 - d_ang) : 11'd0;
	assign x_ang = {s_ang, 7'b0};

	assign d_sd = (state_q == S_SIDEL) ? sl_q : sr_q;
	assign c_sd = (d_sd > 13'd160) ? 8'd160 : d_sd[7:0];
	assign x_sd = {c_sd, 7'b0};

	assign sd    = $signed({1'b0, sdl_q}) - $signed({1'b0, sdr_q});
	assign clr17 = 17'(clr_q);
	assign a17   = $signed({4'b0, a_q});
	assign b17   = $signed({4'b0, b_q});
	assign sd17  = back_q ? -17'(sd) : 17'(sd);
	assign m_l   = clr17 + a17 - b17 + sd17;
	assign m_r   = clr17 - a17 + b17 - sd17;
	assign nr_neg = -(17'(nr_q));

	always_comb begin
		unique case (state_q)
			S_CLR: begin
				mul_a = $signed({2'b0, x_clr});
				mul_b = RECIP_25;
			end
			S_ANGL, S_ANGR: begin
				mul_a = $signed({1'b0, x_ang});
				mul_b = RECIP_35;
			end
			S_A, S_B: begin
				mul_a = $signed({6'b0, ang_q});
				mul_b = $signed({10'b0, cfg.sens});
			end
			S_SIDEL, S_SIDER: begin
				mul_a = $signed({4'b0, x_sd});
				mul_b = RECIP_5;
			end
			S_ML: begin
				mul_a = 19'(m_l);
				mul_b = 23'(wanted_q);
			end
			S_MR: begin
				mul_a = 19'(m_r);
				mul_b = 23'(wanted_q);
			end
			S_GL: begin
				mul_a = 19'(nl_q);
				mul_b = $signed({8'b0, cfg.gain});
			end
			S_GR: begin
				mul_a = 19'(nr_neg);
				mul_b = $signed({8'b0, cfg.gain});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// speed = sat16(floor((prev + floor(wanted*m/4096)) / 4))
	assign pw      = p_q[32:12];
	assign spd_sum = 22'((state_q == S_ML) ? prev_l_q : prev_r_q) + 22'(pw);
	assign spd_new = sat16(spd_sum[21:2]);
	assign vel_new = sat18(p_q[31:12]);

	always_ff @(posedge clk) begin
		if (accept) begin
			if (go_back) begin
				dl_q <= rear_left_dist;
				dc_q <= rear_center_dist;
				dr_q <= rear_right_dist;
			end else begin
				dl_q <= front_left_dist;
				dc_q <= front_center_dist;
				dr_q <= front_right_dist;
			end
			sl_q <= side_left_dist;
			sr_q <= side_right_dist;
		end
		if (ph_q) begin
			unique case (state_q)
				S_CLR:   clr_q <= $signed({1'b0, p_q[36:24]}) - 14'sd615;
				S_ANGL:  ang_q <= p_q[36:24];
				S_A:     a_q   <= p_q[24:12];
				S_ANGR:  ang_q <= p_q[36:24];
				S_B:     b_q   <= p_q[24:12];
				S_SIDEL: sdl_q <= p_q[36:24];
				S_SIDER: sdr_q <= p_q[36:24];
				S_GL:    mvl_q <= vel_new;
				S_GR:    mvr_q <= vel_new;
				default: ;
			endcase
		end
		if (state_q == S_DONE && (!out_valid_q || out_ready)) begin
			ls_q  <= nl_q;
			rs_q  <= nr_q;
			lmv_q <= mvl_q;
			rmv_q <= mvr_q;
			fs_q  <= !back_q || rev_q;
			rsn_q <= back_q || rev_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ph_q        <= 1'b0;
			back_q      <= 1'b0;
			rev_q       <= 1'b0;
			fresh_q     <= 1'b1;
			wanted_q    <= $signed({1'b0, CRUISE_RST});
			prev_l_q    <= '0;
			prev_r_q    <= '0;
			nl_q        <= '0;
			nr_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && (!out_valid_q || out_ready))
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			if (cruise_ld.ld && fresh_q)
				wanted_q <= $signed({1'b0, cruise_ld.val});
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						back_q <= go_back;
						rev_q  <= !(go_fwd || go_back);
						ph_q   <= 1'b0;
						if (go_fwd || go_back) begin
							state_q <= S_CLR;
						end else begin
							wanted_q <= wanted_neg;
							nl_q     <= wanted_neg;
							nr_q     <= wanted_neg;
							state_q  <= S_GL;
						end
					end
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						prev_l_q    <= nl_q;
						prev_r_q    <= nr_q;
						fresh_q     <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					// issue on phase 0, write back on phase 1
					ph_q <= !ph_q;
					if (ph_q) begin
						if (state_q == S_ML)
							nl_q <= spd_new;
						if (state_q == S_MR)
							nr_q <= spd_new;
						state_q <= (state_q == S_GR) ? S_DONE : state_q + 4'd1;
					end
				end
			endcase
		end
	end

	assign out_valid       = out_valid_q;
	assign left_speed      = ls_q;
	assign right_speed     = rs_q;
	assign left_motor_vel  = lmv_q;
	assign right_motor_vel = rmv_q;
	assign front_sense_on  = fs_q;
	assign rear_sense_on   = rsn_q;

endmodule

### rtl/obstacle_avoid_drive_mixer.sv
// Obstacle avoiding drive mixer. One item is one control tick of eight distance
// readings; it yields one item of wheel speeds, motor velocities and sensor
// enables. All products go through a single shared 19x23 multiplier, each
// taking an issue step and a write-back step: a forward or backward mix
// runs eleven multiplies, a direction reversal runs two. in_ready is high
// only while no tick is in work; a finished result waits in the output
// register, and the next tick can be accepted meanwhile. Configuration writes
// are taken in every cycle.
module obstacle_avoid_drive_mixer import odm_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_DATA_W-1:0]    cfg_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [DIST_W-1:0]        front_left_dist,
	input  logic [DIST_W-1:0]        front_center_dist,
	input  logic [DIST_W-1:0]        front_right_dist,
	input  logic [DIST_W-1:0]        rear_left_dist,
	input  logic [DIST_W-1:0]        rear_center_dist,
	input  logic [DIST_W-1:0]        rear_right_dist,
	input  logic [DIST_W-1:0]        side_left_dist,
	input  logic [DIST_W-1:0]        side_right_dist,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [SPD_W-1:0] left_speed,
	output logic signed [SPD_W-1:0] right_speed,
	output logic signed [VEL_W-1:0] left_motor_vel,
	output logic signed [VEL_W-1:0] right_motor_vel,
	output logic                     front_sense_on,
	output logic                     rear_sense_on
);

	cfg_regs_t  regs;
	cruise_ld_t cruise_ld;

	assign cfg_ready = 1'b1;

	odm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.regs      (regs),
		.cruise_ld (cruise_ld)
	);

	odm_core u_core (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg               (regs),
		.cruise_ld         (cruise_ld),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.front_left_dist   (front_left_dist),
		.front_center_dist (front_center_dist),
		.front_right_dist  (front_right_dist),
		.rear_left_dist    (rear_left_dist),
		.rear_center_dist  (rear_center_dist),
		.rear_right_dist   (rear_right_dist),
		.side_left_dist    (side_left_dist),
		.side_right_dist   (side_right_dist),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.left_speed        (left_speed),
		.right_speed       (right_speed),
		.left_motor_vel    (left_motor_vel),
		.right_motor_vel   (right_motor_vel),
		.front_sense_on    (front_sense_on),
		.rear_sense_on     (rear_sense_on)
	);

endmodule

### rtl/odm_chk.sv
module odm_chk import odm_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_valid,
	input logic                     in_ready,
	input logic                     out_valid,
	input logic                     out_ready,
	input logic signed [SPD_W-1:0] left_speed,
	input logic signed [SPD_W-1:0] right_speed,
	input logic signed [VEL_W-1:0] left_motor_vel,
	input logic                     front_sense_on,
	input logic                     rear_sense_on
);

	// one tick in work at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("in_ready high right after an item was accepted");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(left_speed)
			&& $stable(left_motor_vel)))
		else $error("stalled result item changed");

	a_some_group: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (front_sense_on || rear_sense_on))
		else $error("result with no sensor group enabled");

	// a reversal drives both wheels to the same speed
	a_reverse_equal: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && front_sense_on && rear_sense_on) |-> (left_speed == right_speed))
		else $error("reversal with unequal wheel speeds");

endmodule

bind obstacle_avoid_drive_mixer odm_chk u_odm_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_ready       (in_ready),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.left_speed     (left_speed),
	.right_speed    (right_speed),
	.left_motor_vel (left_motor_vel),
	.front_sense_on (front_sense_on),
	.rear_sense_on  (rear_sense_on)
);

### tb/sv/drive_mix_check.sv
module drive_mix_check import odm_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_valid,
	input  logic                    cfg_ready,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data,
	input  logic                    in_valid,
	input  logic                    in_ready,
	input  logic [DIST_W-1:0]       front_left_dist,
	input  logic [DIST_W-1:0]       front_center_dist,
	input  logic [DIST_W-1:0]       front_right_dist,
	input  logic [DIST_W-1:0]       rear_left_dist,
	input  logic [DIST_W-1:0]       rear_center_dist,
	input  logic [DIST_W-1:0]       rear_right_dist,
	input  logic [DIST_W-1:0]       side_left_dist,
	input  logic [DIST_W-1:0]       side_right_dist,
	input  logic                    out_valid,
	input  logic                    out_ready,
	input  logic signed [SPD_W-1:0] left_speed,
	input  logic signed [SPD_W-1:0] right_speed,
	input  logic signed [VEL_W-1:0] left_motor_vel,
	input  logic signed [VEL_W-1:0] right_motor_vel,
	input  logic                    front_sense_on,
	input  logic                    rear_sense_on,
	output int                      fails,
	output int                      backlog
);

	typedef struct packed {
		logic [SPD_W-1:0] left_speed;
		logic [SPD_W-1:0] right_speed;
		logic [VEL_W-1:0] left_motor_vel;
		logic [VEL_W-1:0] right_motor_vel;
		logic             front_sense_on;
		logic             rear_sense_on;
	} drive_cmd_t;

	drive_cmd_t due_cmds[$];
	cfg_regs_t  regs;
	longint     prev_l;
	longint     prev_r;
	longint     wanted_spd;
	bit         fresh;

	function automatic longint div_floor(input longint n, input longint d);
		if (n >= 0)
			return n / d;
		return -((-n + d - 1) / d);
	endfunction

	function automatic longint clamp(input longint v, input longint lo, input longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	// normalized clearance of a sensor group, may go below zero
	function automatic longint clearance_q12(input longint l, input longint c, input longint r);
		longint m;
		m = l;
		if (c < m)
			m = c;
		if (r < m)
			m = r;
		m = m - 120;
		if (m > 800)
			m = 800;
		return div_floor(m * 4096, 800);
	endfunction

	function automatic longint angle_term(input longint d);
		longint s;
		s = 1120 - d;
		if (s < 0)
			s = 0;
		return (((s * 4096) / 1120) * longint'(regs.sens)) / 4096;
	endfunction

	function automatic longint side_term(input longint d);
		if (d > 160)
			d = 160;
		return (d * 4096) / 160;
	endfunction

	// advance the wheel state by one tick and return the command it yields
	function automatic drive_cmd_t mix_tick(input longint fl, fc, fr, rl, rc, rr, sl, sr);
		drive_cmd_t c;
		longint     sum, thr, cl, a, b, sd, ml, mr, nl, nr, lv, rv;
		bit         back;
		sum = prev_l + prev_r;
		thr = 2 * longint'(regs.min_spd);
		if (fresh || sum > thr || sum < -thr) begin
			back = !fresh && sum < -thr;
			if (back) begin
				cl = clearance_q12(rl, rc, rr);
				a = angle_term(rl);
				b = angle_term(rr);
				sd = side_term(sr) - side_term(sl);
			end else begin
				cl = clearance_q12(fl, fc, fr);
				a = angle_term(fl);
				b = angle_term(fr);
				sd = side_term(sl) - side_term(sr);
			end
			ml = cl + a - b + sd;
			mr = cl - a + b - sd;
			if (fresh) begin
				prev_l = 0;
				prev_r = 0;
			end
			nl = clamp(div_floor(prev_l + div_floor(wanted_spd * ml, 4096), 4), -32768, 32767);
			nr = clamp(div_floor(prev_r + div_floor(wanted_spd * mr, 4096), 4), -32768, 32767);
			c.front_sense_on = !back;
			c.rear_sense_on = back;
		end else begin
			wanted_spd = clamp(-wanted_spd, -32768, 32767);
			nl = wanted_spd;
			nr = wanted_spd;
			c.front_sense_on = 1'b1;
			c.rear_sense_on = 1'b1;
		end
		fresh = 1'b0;
		prev_l = nl;
		prev_r = nr;
		lv = clamp(div_floor(longint'(regs.gain) * nl, 4096), -131072, 131071);
		rv = clamp(div_floor(-(longint'(regs.gain) * nr), 4096), -131072, 131071);
		c.left_speed = nl[SPD_W-1:0];
		c.right_speed = nr[SPD_W-1:0];
		c.left_motor_vel = lv[VEL_W-1:0];
		c.right_motor_vel = rv[VEL_W-1:0];
		return c;
	endfunction

	task automatic check_field(input string name, input longint want, input longint seen);
		if (want != seen) begin
			fails++;
			$display("%0t %s: expected %0d, actual %0d", $time, name, want, seen);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		drive_cmd_t due;
		if (!arst_n) begin
			regs.cruise = CRUISE_RST;
			regs.min_spd = MIN_RST;
			regs.sens = SENS_RST;
			regs.gain = GAIN_RST;
			prev_l = 0;
			prev_r = 0;
			wanted_spd = longint'(CRUISE_RST);
			fresh = 1'b1;
			due_cmds.delete();
			backlog = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_CRUISE: begin
						regs.cruise = cfg_data;
						// before the first tick the cruise value also becomes the wanted speed
						if (fresh)
							wanted_spd = longint'(cfg_data);
					end
					REG_MIN:  regs.min_spd = cfg_data;
					REG_SENS: regs.sens = cfg_data[12:0];
					REG_GAIN: regs.gain = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				due_cmds.push_back(mix_tick(longint'(front_left_dist),
					longint'(front_center_dist), longint'(front_right_dist),
					longint'(rear_left_dist), longint'(rear_center_dist),
					longint'(rear_right_dist), longint'(side_left_dist),
					longint'(side_right_dist)));
			if (out_valid && out_ready) begin
				if (due_cmds.size() == 0) begin
					fails++;
					$display("%0t unexpected item: expected none, actual speeds %0d %0d",
						$time, left_speed, right_speed);
				end else begin
					due = due_cmds.pop_front();
					check_field("left_speed", longint'($signed(due.left_speed)),
						longint'(left_speed));
					check_field("right_speed", longint'($signed(due.right_speed)),
						longint'(right_speed));
					check_field("left_motor_vel", longint'($signed(due.left_motor_vel)),
						longint'(left_motor_vel));
					check_field("right_motor_vel", longint'($signed(due.right_motor_vel)),
						longint'(right_motor_vel));
					check_field("front_sense_on", longint'(due.front_sense_on),
						longint'(front_sense_on));
					check_field("rear_sense_on", longint'(due.rear_sense_on),
						longint'(rear_sense_on));
				end
			end
			backlog = due_cmds.size();
		end
	end

endmodule

### tb/sv/tb.sv
module tb;
	import odm_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd4;

	typedef logic [DIST_W-1:0] dist_t;

	typedef struct packed {
		dist_t fl;
		dist_t fc;
		dist_t fr;
		dist_t rl;
		dist_t rc;
		dist_t rr;
		dist_t sl;
		dist_t sr;
	} scan_t;

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [CFG_IDX_W-1:0]    cfg_index;
	logic [CFG_DATA_W-1:0]   cfg_data;
	logic                    in_valid;
	logic                    in_ready;
	dist_t                   front_left_dist;
	dist_t                   front_center_dist;
	dist_t                   front_right_dist;
	dist_t                   rear_left_dist;
	dist_t                   rear_center_dist;
	dist_t                   rear_right_dist;
	dist_t                   side_left_dist;
	dist_t                   side_right_dist;
	logic                    out_valid;
	logic                    out_ready;
	logic signed [SPD_W-1:0] left_speed;
	logic signed [SPD_W-1:0] right_speed;
	logic signed [VEL_W-1:0] left_motor_vel;
	logic signed [VEL_W-1:0] right_motor_vel;
	logic                    front_sense_on;
	logic                    rear_sense_on;
	int                      fails;
	int                      backlog;
	int                      tx_calm;

	obstacle_avoid_drive_mixer u_top (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.front_left_dist   (front_left_dist),
		.front_center_dist (front_center_dist),
		.front_right_dist  (front_right_dist),
		.rear_left_dist    (rear_left_dist),
		.rear_center_dist  (rear_center_dist),
		.rear_right_dist   (rear_right_dist),
		.side_left_dist    (side_left_dist),
		.side_right_dist   (side_right_dist),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.left_speed        (left_speed),
		.right_speed       (right_speed),
		.left_motor_vel    (left_motor_vel),
		.right_motor_vel   (right_motor_vel),
		.front_sense_on    (front_sense_on),
		.rear_sense_on     (rear_sense_on)
	);

	drive_mix_check u_check (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.front_left_dist   (front_left_dist),
		.front_center_dist (front_center_dist),
		.front_right_dist  (front_right_dist),
		.rear_left_dist    (rear_left_dist),
		.rear_center_dist  (rear_center_dist),
		.rear_right_dist   (rear_right_dist),
		.side_left_dist    (side_left_dist),
		.side_right_dist   (side_right_dist),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.left_speed        (left_speed),
		.right_speed       (right_speed),
		.left_motor_vel    (left_motor_vel),
		.right_motor_vel   (right_motor_vel),
		.front_sense_on    (front_sense_on),
		.rear_sense_on     (rear_sense_on),
		.fails             (fails),
		.backlog           (backlog)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic scan_t scan_of(input dist_t fl, fc, fr, rl, rc, rr, sl, sr);
		scan_t s;
		s.fl = fl;
		s.fc = fc;
		s.fr = fr;
		s.rl = rl;
		s.rc = rc;
		s.rr = rr;
		s.sl = sl;
		s.sr = sr;
		return s;
	endfunction

	// bias toward the range where clearance, angled and side terms all move
	function automatic dist_t rand_dist();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return dist_t'($urandom_range(0, 1300));
			4, 5, 6:    return dist_t'($urandom_range(0, 7200));
			7:          return dist_t'($urandom_range(100, 180));
			8:          return dist_t'($urandom_range(0, 8191));
			default: begin
				case ($urandom_range(0, 5))
					0:       return 0;
					1:       return 120;
					2:       return 160;
					3:       return 1120;
					4:       return 7200;
					default: return 8191;
				endcase
			end
		endcase
	endfunction

	function automatic scan_t random_scan();
		dist_t v;
		// balanced view: no steering and clearance near zero, so speeds decay toward a reversal
		if ($urandom_range(0, 7) == 0) begin
			v = dist_t'($urandom_range(100, 200));
			return scan_of(v, v, v, v, v, v, v, v);
		end
		return scan_of(rand_dist(), rand_dist(), rand_dist(), rand_dist(), rand_dist(),
			rand_dist(), rand_dist(), rand_dist());
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
	endtask

	task automatic load_regs(input logic [CFG_DATA_W-1:0] cruise, min_spd, sens, gain);
		write_reg(REG_CRUISE, cruise);
		write_reg(REG_MIN, min_spd);
		write_reg(REG_SENS, sens);
		write_reg(REG_GAIN, gain);
		write_reg(REG_SPARE + CFG_IDX_W'($urandom_range(0, 3)), CFG_DATA_W'($urandom));
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_scan(input scan_t s);
		int gap;
		if (tx_calm > 0) begin
			tx_calm--;
			gap = 0;
		end else if ($urandom_range(0, 19) == 0) begin
			tx_calm = $urandom_range(10, 40);
			gap = 0;
		end else begin
			gap = $urandom_range(0, 17);
		end
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		front_left_dist <= s.fl;
		front_center_dist <= s.fc;
		front_right_dist <= s.fr;
		rear_left_dist <= s.rl;
		rear_center_dist <= s.rc;
		rear_right_dist <= s.rr;
		side_left_dist <= s.sl;
		side_right_dist <= s.sr;
		do @(posedge clk); while (!(in_valid && in_ready));
	endtask

	// drop valid and hold until every issued tick has come back
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (backlog != 0) @(negedge clk);
	endtask

	initial begin : stimulus
		int ph;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		front_left_dist = '0;
		front_center_dist = '0;
		front_right_dist = '0;
		rear_left_dist = '0;
		rear_center_dist = '0;
		rear_right_dist = '0;
		side_left_dist = '0;
		side_right_dist = '0;
		tx_calm = 0;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// cruise written before the first tick also sets the wanted speed
		load_regs(16384, 410, 819, 12288);
		send_scan(scan_of(0, 0, 0, 0, 0, 0, 0, 0));
		send_scan(scan_of(7200, 7200, 7200, 7200, 7200, 7200, 7200, 7200));
		send_scan(scan_of(8191, 8191, 8191, 8191, 8191, 8191, 8191, 8191));
		send_scan(scan_of(0, 7200, 7200, 7200, 7200, 0, 0, 160));
		send_scan(scan_of(7200, 7200, 0, 0, 7200, 7200, 160, 0));
		repeat (5) send_scan(scan_of(120, 120, 120, 120, 120, 120, 120, 120));
		send_scan(scan_of(1120, 1120, 1120, 1120, 1120, 1120, 160, 160));
		send_scan(scan_of(5000, 920, 5000, 0, 0, 0, 8191, 0));
		send_scan(scan_of(0, 0, 0, 5000, 920, 5000, 0, 8191));
		repeat (4) send_scan(scan_of(120, 120, 120, 120, 120, 120, 120, 120));
		send_scan(scan_of(2730, 5461, 2730, 5461, 2730, 5461, 2730, 5461));
		send_scan(scan_of(5461, 2730, 5461, 2730, 5461, 2730, 5461, 2730));
		settle();

		for (ph = 0; ph < 8; ph++) begin
			case (ph)
				0: load_regs(12288, 410, 819, 12288);
				1: load_regs(32767, 0, 4096, 32767);
				2: load_regs(0, 32767, 0, 0);
				3: load_regs(CFG_DATA_W'($urandom_range(1, 32767)), 32767,
					CFG_DATA_W'($urandom_range(0, 4096)),
					CFG_DATA_W'($urandom_range(0, 32767)));
				4: load_regs(32767, 1, 8191, 32767);
				5: load_regs(CFG_DATA_W'($urandom_range(0, 32767)),
					CFG_DATA_W'($urandom_range(0, 32767)),
					CFG_DATA_W'($urandom_range(0, 32767)),
					CFG_DATA_W'($urandom_range(0, 32767)));
				6: load_regs(CFG_DATA_W'($urandom_range(4096, 32767)),
					CFG_DATA_W'($urandom_range(0, 2000)),
					CFG_DATA_W'($urandom_range(0, 4096)),
					CFG_DATA_W'($urandom_range(0, 32767)));
				default: load_regs(20000, 410, 819, 12288);
			endcase
			repeat (100) send_scan(random_scan());
			settle();
		end

		repeat (40) @(posedge clk);
		if (fails == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin : drain
		int stall;
		int taken;
		int rx_calm;
		out_ready = 1'b0;
		taken = 0;
		rx_calm = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			// long hold so the output register fills and the input backs up
			if (taken == 300 || taken == 600) begin
				stall = 150;
			end else if (rx_calm > 0) begin
				rx_calm--;
				stall = 0;
			end else if ($urandom_range(0, 19) == 0) begin
				rx_calm = $urandom_range(10, 40);
				stall = 0;
			end else begin
				stall = $urandom_range(0, 17);
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
			taken++;
		end
	end

	initial begin : watchdog
		#600000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
